/* hdl/umtw_pkg.sv */
// Shared types and constants for the markup text width block.
package umtw_pkg;

   // Default number of glyph width entries.
   localparam int GLYPHS_DEFAULT = 256;

   localparam int SUM_W   = 20;
   localparam int WIDTH_W = 7;
   localparam int ACC_W   = 31;

   // First code point covered by the width table.
   localparam logic [7:0] CHAR_BASE = 8'd32;

   // Escape characters.
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   // UTF-8 lead byte masks and codes.
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] LEAD5_MASK = 8'hFC;
   localparam logic [7:0] LEAD5_CODE = 8'hF8;
   localparam logic [7:0] LEAD6_MASK = 8'hFE;
   localparam logic [7:0] LEAD6_CODE = 8'hFC;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] DATA_MASK  = 8'h3F;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_ESCAPE  = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] text_byte;
      logic       is_last;
      logic [7:0] glyph_index;
      logic [6:0] glyph_width;
   } req_word_type;

   typedef struct packed {
      logic [19:0] total_width;
      logic [1:0]  status;
   } rsp_word_type;

   // What the decoder hands to the accumulate stage per text byte.
   typedef struct packed {
      logic       add;
      logic       last;
      logic [1:0] status;
   } glyph_op_type;

endpackage

/* hdl/umtw_table.sv */
// Glyph width memory: one write port, one registered read port.
module umtw_table
   import umtw_pkg::*;
#(
   parameter int GLYPHS = GLYPHS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(GLYPHS)-1:0] wr_addr,
   input  logic [WIDTH_W-1:0]        wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(GLYPHS)-1:0] rd_addr,
   output logic [WIDTH_W-1:0]        rd_data
);

   logic [WIDTH_W-1:0] mem [GLYPHS];
   logic [WIDTH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/umtw_decode.sv */
// UTF-8 and escape decoder: per-string state, glyph lookup index and status.
module umtw_decode
   import umtw_pkg::*;
#(
   parameter int GLYPHS = GLYPHS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [7:0]                text_byte,
   input  logic                      is_last,
   output logic [$clog2(GLYPHS)-1:0] index,
   output glyph_op_type              op
);

   localparam int IW = $clog2(GLYPHS);

   logic             stop_ff, stop_in;
   logic             tilde_ff, tilde_in;
   logic             fmt_ff, fmt_in;
   logic [2:0]       rem_ff, rem_in;
   logic [ACC_W-1:0] acc_ff, acc_in;

   logic [ACC_W-1:0] cp;
   logic [ACC_W-1:0] cp_off;
   logic             fin;
   logic             dec;
   logic             add_req;
   logic             in_range;

   always_comb begin
      stop_in  = stop_ff;
      tilde_in = tilde_ff;
      fmt_in   = fmt_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      cp       = '0;
      fin      = 1'b0;
      dec      = 1'b0;
      add_req  = 1'b0;
      if (!stop_ff) begin
         if (tilde_ff) begin
            tilde_in = 1'b0;
            case (text_byte)
               CH_BAR, CH_BANG: begin
               end
               CH_LT, CH_GT: begin
                  fmt_in = 1'b0;
               end
               CH_TILDE: begin
                  // doubled tilde draws one tilde
                  cp      = ACC_W'(CH_TILDE);
                  add_req = 1'b1;
               end
               default: begin
                  fmt_in = ~fmt_ff;
                  dec    = 1'b1;
               end
            endcase
         end else begin
            dec = 1'b1;
         end
         if (dec) begin
            if (rem_ff == 3'd0) begin
               if ((text_byte & ASCII_MASK) == 8'h00) begin
                  cp  = ACC_W'(text_byte);
                  fin = 1'b1;
               end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
                  acc_in = ACC_W'(text_byte & ~LEAD2_MASK);
                  rem_in = 3'd1;
               end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
                  acc_in = ACC_W'(text_byte & ~LEAD3_MASK);
                  rem_in = 3'd2;
               end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
                  acc_in = ACC_W'(text_byte & ~LEAD4_MASK);
                  rem_in = 3'd3;
               end else if ((text_byte & LEAD5_MASK) == LEAD5_CODE) begin
                  acc_in = ACC_W'(text_byte & ~LEAD5_MASK);
                  rem_in = 3'd4;
               end else if ((text_byte & LEAD6_MASK) == LEAD6_CODE) begin
                  acc_in = ACC_W'(text_byte & ~LEAD6_MASK);
                  rem_in = 3'd5;
               end else begin
                  stop_in = 1'b1;
               end
            end else if ((text_byte & CONT_MASK) != CONT_CODE) begin
               stop_in = 1'b1;
            end else begin
               acc_in = {acc_ff[ACC_W-7:0], text_byte[5:0] & DATA_MASK[5:0]};
               rem_in = rem_ff - 3'd1;
               if (rem_in == 3'd0) begin
                  cp  = acc_in;
                  fin = 1'b1;
               end
            end
         end
         if (fin) begin
            if (cp == ACC_W'(CH_TILDE)) begin
               tilde_in = 1'b1;
            end else begin
               add_req = 1'b1;
            end
         end
      end
   end

   // out-of-range and control code points fall back to entry 0
   assign cp_off   = cp - ACC_W'(CHAR_BASE);
   assign in_range = (cp >= ACC_W'(CHAR_BASE)) && (cp_off < ACC_W'(GLYPHS));
   assign index    = in_range ? cp_off[IW-1:0] : '0;

   always_comb begin
      op.add  = add_req && !fmt_in;
      op.last = is_last;
      if (stop_in) begin
         op.status = STATUS_INVALID;
      end else if (tilde_in) begin
         op.status = STATUS_ESCAPE;
      end else if (rem_in != 3'd0) begin
         op.status = STATUS_INVALID;
      end else begin
         op.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff  <= 1'b0;
         tilde_ff <= 1'b0;
         fmt_ff   <= 1'b0;
         rem_ff   <= 3'd0;
         acc_ff   <= '0;
      end else if (take) begin
         if (is_last) begin
            stop_ff  <= 1'b0;
            tilde_ff <= 1'b0;
            fmt_ff   <= 1'b0;
            rem_ff   <= 3'd0;
            acc_ff   <= '0;
         end else begin
            stop_ff  <= stop_in;
            tilde_ff <= tilde_in;
            fmt_ff   <= fmt_in;
            rem_ff   <= rem_in;
            acc_ff   <= acc_in;
         end
      end
   end

endmodule

/* hdl/umtw_accum.sv */
// Width accumulator stage and result output register.
module umtw_accum
   import umtw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  glyph_op_type       op,
   input  logic [WIDTH_W-1:0] rd_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output rsp_word_type       rsp_word,
   output logic               blocked
);

   logic           s1_valid_ff;
   glyph_op_type   s1_op_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum_in;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_word_ff;

   // a finished string cannot leave stage 1 while the output word is held
   assign blocked = s1_valid_ff && s1_op_ff.last && rsp_valid_ff && rsp_stall;

   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(rd_data) + (SUM_W+1)'(1);

   always_comb begin
      if (!s1_op_ff.add) begin
         sum_in = sum_ff;
      end else if (sum_wide[SUM_W]) begin
         sum_in = '1;
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!blocked) begin
            s1_valid_ff <= take;
            if (s1_valid_ff) begin
               sum_ff <= s1_op_ff.last ? '0 : sum_in;
            end
         end
         if (!blocked && s1_valid_ff && s1_op_ff.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!blocked) begin
         s1_op_ff <= op;
         if (s1_valid_ff && s1_op_ff.last) begin
            rsp_word_ff.total_width <= sum_in;
            rsp_word_ff.status      <= s1_op_ff.status;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* hdl/utf8_markup_text_width.sv */
// Top level of the markup string pixel width measurer.
//
// Input channel (req_): one word per cycle unless stalled. mode 0 loads
// glyph_width into width table entry glyph_index (ignored when the index
// is past GLYPHS). mode 1 carries one UTF-8 byte of a string; is_last marks
// its final byte. Output channel (rsp_): one word per string, after its
// last byte, holding the saturated total width and a status (ok, invalid
// UTF-8, open escape). A last byte reaches rsp_ via the stage 1 and output
// registers. Throughput: one word per cycle unless stalled; each text byte
// does one width table read (one registered memory port) and one add in
// the stage after. A table load is visible to a text byte accepted in the
// very next cycle. Stall: rsp_ holds its word while rsp_stall is high.
// Input words keep flowing until a second finished string reaches the
// accumulate stage; then req_stall rises until the output word is taken.
// Reset clears the string state and output; the width table is not
// cleared and must be loaded before the entries that text uses.
module utf8_markup_text_width
   import umtw_pkg::*;
#(
   parameter int GLYPHS = GLYPHS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int IW = $clog2(GLYPHS);
   // wide enough for both the 8-bit load index and the entry count
   localparam int LW = ((IW > 8) ? IW : 8) + 1;

   logic            blocked;
   logic            accept;
   logic            take_text;
   logic            load;
   logic [LW-1:0]   load_idx;
   logic [IW-1:0]   rd_index;
   logic [WIDTH_W-1:0] rd_data;
   glyph_op_type    op;

   assign req_stall = blocked;
   assign accept    = req_valid && !blocked;
   assign take_text = accept && req_word.mode;

   // table loads: out-of-range indexes are dropped
   assign load_idx = LW'(req_word.glyph_index);
   assign load     = accept && !req_word.mode && (load_idx < LW'(GLYPHS));

   umtw_decode #(
      .GLYPHS(GLYPHS)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .take     (take_text),
      .text_byte(req_word.text_byte),
      .is_last  (req_word.is_last),
      .index    (rd_index),
      .op       (op)
   );

   umtw_table #(
      .GLYPHS(GLYPHS)
   ) u_table (
      .clock  (clock),
      .wr_en  (load),
      .wr_addr(load_idx[IW-1:0]),
      .wr_data(req_word.glyph_width),
      .rd_en  (!blocked),
      .rd_addr(rd_index),
      .rd_data(rd_data)
   );

   umtw_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .take     (take_text),
      .op       (op),
      .rd_data  (rd_data),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word),
      .blocked  (blocked)
   );

endmodule

/* hdl/umtw_checker.sv */
// Port-level checker for the markup text width block, bound to the top level.
module umtw_checker
   import umtw_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // held output word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status == STATUS_OK ||
                     rsp_word.status == STATUS_INVALID ||
                     rsp_word.status == STATUS_ESCAPE))
      else $error("undefined status code");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a fresh result comes from a last text byte accepted earlier
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_word.mode &&
                                 req_word.is_last && !reset, 2))
      else $error("result without a last text byte");

endmodule

bind utf8_markup_text_width umtw_checker u_umtw_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_word (req_word),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_word (rsp_word)
);

/* bench/umtw_width_checker.sv */
// Watches both channels of the text width block, predicts each string's result and compares.
module umtw_width_checker
   import umtw_pkg::*;
#(
   parameter int GLYPHS = GLYPHS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_word_type    req_word,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_word_type    rsp_word,
   output int unsigned     errors,
   output int unsigned     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [SUM_W-1:0] SUM_TOP = '1;

   // shadow of the glyph width memory and of the per-string decode state
   logic [WIDTH_W-1:0] glyph_tab [GLYPHS];
   logic [SUM_W-1:0]   sum_px;
   logic [ACC_W-1:0]   cp_acc;
   logic [2:0]         cont_left;
   logic               tilde_seen;
   logic               fmt_on;
   logic [1:0]         stop_code;

   rsp_word_type       width_due [$];
   int unsigned        fail_count = 0;

   assign errors = fail_count;

   function void clear_line();
      sum_px     = '0;
      cp_acc     = '0;
      cont_left  = '0;
      tilde_seen = 1'b0;
      fmt_on     = 1'b0;
      stop_code  = STATUS_OK;
   endfunction

   function void add_glyph_px(input logic [ACC_W-1:0] cp);
      int unsigned idx;
      int unsigned wide;
      idx = 0;
      if (fmt_on) return;
      // controls and anything past the table fall back to entry 0
      if (cp >= CHAR_BASE && cp - CHAR_BASE < GLYPHS) idx = cp - CHAR_BASE;
      wide = sum_px + glyph_tab[idx] + 1;
      sum_px = (wide > SUM_TOP) ? SUM_TOP : wide[SUM_W-1:0];
   endfunction

   function void close_code_point(input logic [ACC_W-1:0] cp);
      if (cp == ACC_W'(CH_TILDE)) tilde_seen = 1'b1;
      else add_glyph_px(cp);
   endfunction

   function void decode_utf8(input logic [7:0] ch);
      if (cont_left == 3'd0) begin
         if ((ch & ASCII_MASK) == 8'h00) begin
            close_code_point(ACC_W'(ch));
         end else if ((ch & LEAD2_MASK) == LEAD2_CODE) begin
            cp_acc = ACC_W'(ch & ~LEAD2_MASK); cont_left = 3'd1;
         end else if ((ch & LEAD3_MASK) == LEAD3_CODE) begin
            cp_acc = ACC_W'(ch & ~LEAD3_MASK); cont_left = 3'd2;
         end else if ((ch & LEAD4_MASK) == LEAD4_CODE) begin
            cp_acc = ACC_W'(ch & ~LEAD4_MASK); cont_left = 3'd3;
         end else if ((ch & LEAD5_MASK) == LEAD5_CODE) begin
            cp_acc = ACC_W'(ch & ~LEAD5_MASK); cont_left = 3'd4;
         end else if ((ch & LEAD6_MASK) == LEAD6_CODE) begin
            cp_acc = ACC_W'(ch & ~LEAD6_MASK); cont_left = 3'd5;
         end else begin
            stop_code = STATUS_INVALID;
         end
      end else if ((ch & CONT_MASK) != CONT_CODE) begin
         stop_code = STATUS_INVALID;
      end else begin
         cp_acc = {cp_acc[ACC_W-7:0], ch[5:0]};
         cont_left = cont_left - 3'd1;
         if (cont_left == 3'd0) close_code_point(cp_acc);
      end
   endfunction

   function void measure_byte(input logic [7:0] ch);
      if (stop_code != STATUS_OK) return;
      if (!tilde_seen) begin
         decode_utf8(ch);
         return;
      end
      // byte after a tilde is an escape code; other bytes toggle format and decode
      tilde_seen = 1'b0;
      case (ch)
         CH_BAR, CH_BANG: ;
         CH_LT, CH_GT:    fmt_on = 1'b0;
         CH_TILDE:        add_glyph_px(ACC_W'(CH_TILDE));
         default: begin
            fmt_on = !fmt_on;
            decode_utf8(ch);
         end
      endcase
   endfunction

   task report(input string what, input int unsigned got, input int unsigned want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (width_due.size() == 0) begin
               report("result count", width_due.size() + 1, width_due.size());
            end else begin
               if (rsp_word.total_width !== width_due[0].total_width)
                  report("total_width", rsp_word.total_width, width_due[0].total_width);
               if (rsp_word.status !== width_due[0].status)
                  report("status", rsp_word.status, width_due[0].status);
               void'(width_due.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            if (!req_word.mode) begin
               if (req_word.glyph_index < GLYPHS)
                  glyph_tab[req_word.glyph_index] = req_word.glyph_width;
            end else begin
               measure_byte(req_word.text_byte);
               if (req_word.is_last) begin
                  rsp_word_type due;
                  due.total_width = sum_px;
                  if (stop_code != STATUS_OK) due.status = stop_code;
                  else if (tilde_seen)        due.status = STATUS_ESCAPE;
                  else if (cont_left != 0)    due.status = STATUS_INVALID;
                  else                        due.status = STATUS_OK;
                  width_due = {width_due, due};
                  clear_line();
               end
            end
         end
      end
      pending <= width_due.size();
   end

endmodule

/* bench/utf8_markup_text_width_test.sv */
// Stimulus and verdict for the markup text width block; checking lives in umtw_width_checker.
module utf8_markup_text_width_test;
   import umtw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int unsigned  errors;
   int unsigned  pending;

   // bytes of the string being built, sent by send_line
   logic [7:0]   text_line [$];
   int unsigned  words_sent = 0;
   // while set, the sender runs back to back with no gaps
   bit           req_rush = 1'b0;
   // receiver side: stall cycles left and its own no-stall stretches
   int unsigned  hold_left = 0;
   bit           rsp_rush = 1'b0;

   always #1 clock = ~clock;

   utf8_markup_text_width uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   umtw_width_checker watch (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .errors    (errors),
      .pending   (pending)
   );

   // Receiver: after every taken result, draw a random stall length. The
   // countdown keeps running while nothing is offered, so stalls also land
   // on idle cycles and on the cycle a result first shows up.
   always @(posedge clock) begin : rsp_side
      int unsigned n;
      if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 15) == 0) rsp_rush = !rsp_rush;
         n = rsp_rush ? 0 : $urandom_range(0, 10);
         hold_left <= n;
         rsp_stall <= (n != 0);
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end
   end

   // Offer one word and hold it until taken, then draw the gap before the
   // next. With no gap, valid simply stays high for the following word.
   task send_word(input req_word_type w);
      int unsigned gap;
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      words_sent++;
      gap = req_rush ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Table load; the text fields ride along with random content.
   task send_load(input logic [7:0] idx, input logic [6:0] px, input logic last);
      req_word_type w;
      w.mode        = 1'b0;
      w.text_byte   = $urandom_range(0, 255);
      w.is_last     = last;
      w.glyph_index = idx;
      w.glyph_width = px;
      send_word(w);
   endtask

   // Send the built string, last byte flagged. Now and then a table load
   // slips in between bytes; the block must apply it in order.
   task send_line();
      req_word_type w;
      for (int i = 0; i < text_line.size(); i++) begin
         if ($urandom_range(0, 15) == 0)
            send_load($urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 1));
         w.mode        = 1'b1;
         w.text_byte   = text_line[i];
         w.is_last     = (i == text_line.size() - 1);
         w.glyph_index = $urandom_range(0, 255);
         w.glyph_width = $urandom_range(0, 127);
         send_word(w);
      end
      text_line.delete();
   endtask

   task put(input logic [7:0] ch);
      text_line = {text_line, ch};
   endtask

   task put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endtask

   // Well-formed sequence of n bytes (2..6) with random payload bits; with
   // chop set the final continuation byte is left off.
   task put_seq(input int n, input bit chop);
      logic [7:0] lead;
      lead = $urandom_range(0, 255);
      case (n)
         2:       lead = LEAD2_CODE | (lead & ~LEAD2_MASK);
         3:       lead = LEAD3_CODE | (lead & ~LEAD3_MASK);
         4:       lead = LEAD4_CODE | (lead & ~LEAD4_MASK);
         5:       lead = LEAD5_CODE | (lead & ~LEAD5_MASK);
         default: lead = LEAD6_CODE | (lead & ~LEAD6_MASK);
      endcase
      put(lead);
      for (int k = 1; k < n - (chop ? 1 : 0); k++)
         put(CONT_CODE | ($urandom_range(0, 255) & DATA_MASK));
   endtask

   // One random string: mostly valid text with escapes and multibyte code
   // points; one string in five may also carry broken bytes.
   task build_line();
      int unsigned tokens;
      int unsigned pick;
      bit          broken;
      broken = ($urandom_range(0, 4) == 0);
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (tokens) begin
         pick = $urandom_range(0, broken ? 99 : 89);
         if (pick < 45) begin
            put($urandom_range(CHAR_BASE, CH_TILDE - 1));
         end else if (pick < 55) begin
            put(CH_TILDE);
            case ($urandom_range(0, 5))
               0:       put(CH_BAR);
               1:       put(CH_BANG);
               2:       put(CH_LT);
               3:       put(CH_GT);
               4:       put(CH_TILDE);
               default: put($urandom_range(0, 255));
            endcase
         end else if (pick < 60) begin
            put(($urandom_range(0, 3) == 0) ? 8'h7F : $urandom_range(0, CHAR_BASE - 1));
         end else if (pick < 85) begin
            put_seq($urandom_range(2, 6), 1'b0);
         end else if (pick < 90) begin
            // bare tilde: whatever token follows is read as an escape
            put(CH_TILDE);
         end else if (pick < 95) begin
            put($urandom_range(8'h80, 8'hFF));
         end else begin
            put_seq($urandom_range(2, 6), 1'b1);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Every entry is loaded before any text, since controls and code
      // points past the table read entry 0 and an unloaded entry is
      // undefined. Extremes of the width go to the first two entries.
      for (int i = 0; i < 256; i++)
         send_load(i, (i == 0) ? 7'd127 : (i == 1) ? 7'd0 : $urandom_range(0, 127), 1'b0);
      // a load flagged last must not produce a result
      send_load(8'd5, 7'd9, 1'b1);

      // plain ASCII, then control codes and DEL
      put_text("A"); send_line();
      put(8'h09); put(8'h00); put(8'h7F); send_line();
      // two-byte code points inside and past the table
      put(8'hC4); put(8'h80); put(8'hC5); put(8'h80); send_line();
      // three and four byte sequences
      put(8'hE2); put(8'h82); put(8'hAC);
      put(8'hF0); put(8'h9F); put(8'h98); put(8'h80); send_line();
      // five byte and the largest six byte sequence
      put(8'hF8); put(8'h88); put(8'h80); put(8'h80); put(8'h80);
      put(8'hFD); put(8'hBF); put(8'hBF); put(8'hBF); put(8'hBF); put(8'hBF); send_line();
      // invalid leads and a stray continuation: bytes after them ignored
      put_text("a"); put(8'hFE); put_text("b"); send_line();
      put(8'hFF); send_line();
      put(8'h80); put_text("c"); send_line();
      // bad continuation byte
      put(8'hC3); put_text("A"); send_line();
      // skipped escapes, format clears, double tilde
      put_text("~|x~!y~<z~>w~~"); send_line();
      // toggle format on and off, clear with ~< and ~>
      put_text("a~bcd~<e~~f~>g~hi~j"); send_line();
      // string ends inside an escape
      put_text("x~"); send_line();
      // string ends inside a sequence
      put_text("a"); put(8'hE2); put(8'h82); send_line();
      // overlong tilde opens an escape, then a skip
      put(8'hC1); put(8'hBE); put_text("|q"); send_line();
      // overlong tilde followed by a raw tilde counts one tilde
      put(8'hC1); put(8'hBE); put(CH_TILDE); send_line();
      // escape before a multibyte lead, and before an invalid lead
      put(CH_TILDE); put(8'hC4); put(8'h80); send_line();
      put(CH_TILDE); put(8'hFF); put_text("z"); send_line();

      // random strings until about 1300 words have gone in all told
      while (words_sent < 1300) begin
         if ($urandom_range(0, 7) == 0) req_rush = !req_rush;
         build_line();
         send_line();
      end
      req_valid <= 1'b0;

      // drain, then leave room for a stray late result
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit: about 1400 words take under 70 us.
   initial begin
      #400_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/umtw_pkg.sv
hdl/umtw_table.sv
hdl/umtw_decode.sv
hdl/umtw_accum.sv
hdl/utf8_markup_text_width.sv
hdl/umtw_checker.sv
bench/umtw_width_checker.sv
bench/utf8_markup_text_width_test.sv
